FILE: design/rcdh_pkg.sv
// ----------------------------------------------------------------------------
// rcdh_pkg
// Shared types, widths and codes of the rotation count sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcdh_pkg;

    // Field and counter widths
    localparam int COUNT_WIDTH = 16;
    localparam int TIMER_WIDTH = 20;
    localparam int SPEED_WIDTH = 8;
    localparam int CMD_WIDTH   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    // Command codes
    localparam logic [CMD_WIDTH-1:0] CMD_TICK     = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_PULSE    = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_DISPENSE = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_HOME     = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_SEEK     = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_CLEAR    = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPENSE_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEEK_TIMEOUT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [COUNT_WIDTH-1:0] DISPENSE_MAX_RST = 16'd100;
    localparam logic [COUNT_WIDTH-1:0] HOME_MAX_RST     = 16'd1;
    localparam logic [TIMER_WIDTH-1:0] SEEK_TIMEOUT_RST = 20'd10000;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]   command;
        logic [COUNT_WIDTH-1:0] rotations;
        logic [SPEED_WIDTH-1:0] speed;
        logic                   motor_running;
    } t_request;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] dispense_max;
        logic [COUNT_WIDTH-1:0] home_max;
        logic [TIMER_WIDTH-1:0] seek_timeout;
    } t_config;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic [COUNT_WIDTH-1:0] target;
        logic                   dispense;
        logic                   home;
        logic                   seek;
        logic                   done;
        logic [TIMER_WIDTH-1:0] elapsed;
        logic                   error;
        logic                   motor;
        logic [SPEED_WIDTH-1:0] speed;
    } t_state;

    typedef struct packed {
        logic                   motor_enable;
        logic [SPEED_WIDTH-1:0] motor_speed;
        logic [COUNT_WIDTH-1:0] rotation_count;
        logic                   dispense_active;
        logic                   home_active;
        logic                   seek_active;
        logic                   home_done;
        logic                   error_code;
        logic                   start_rejected;
    } t_result;

endpackage

`default_nettype wire

FILE: design/rcdh_if.sv
// ----------------------------------------------------------------------------
// rcdh_if
// Request, result and configuration channels of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcdh_req_if import rcdh_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_WIDTH-1:0]   command;
    logic [COUNT_WIDTH-1:0] rotations;
    logic [SPEED_WIDTH-1:0] speed;
    logic                   motor_running;

    modport source (output valid, command, rotations, speed, motor_running, input ready);
    modport sink   (input valid, command, rotations, speed, motor_running, output ready);
endinterface

interface rcdh_rsp_if import rcdh_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   motor_enable;
    logic [SPEED_WIDTH-1:0] motor_speed;
    logic [COUNT_WIDTH-1:0] rotation_count;
    logic                   dispense_active;
    logic                   home_active;
    logic                   seek_active;
    logic                   home_done;
    logic                   error_code;
    logic                   start_rejected;

    modport source (output valid, motor_enable, motor_speed, rotation_count,
                    dispense_active, home_active, seek_active, home_done,
                    error_code, start_rejected, input ready);
    modport sink   (input valid, motor_enable, motor_speed, rotation_count,
                    dispense_active, home_active, seek_active, home_done,
                    error_code, start_rejected, output ready);
endinterface

interface rcdh_cfg_if import rcdh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/rcdh_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcdh_cfg_regs
// Configuration registers: limits and seek timeout, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdh_cfg_regs import rcdh_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcdh_cfg_if.sink   i_cfg,
    output t_config    o_config
);

    t_config r_config;

    // Always take writes; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;
    assign o_config    = r_config;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_config.dispense_max <= DISPENSE_MAX_RST;
            r_config.home_max     <= HOME_MAX_RST;
            r_config.seek_timeout <= SEEK_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DISPENSE_MAX: begin
                    r_config.dispense_max <= i_cfg.data[COUNT_WIDTH-1:0];
                end
                REG_HOME_MAX: begin
                    r_config.home_max <= i_cfg.data[COUNT_WIDTH-1:0];
                end
                REG_SEEK_TIMEOUT: begin
                    r_config.seek_timeout <= i_cfg.data[TIMER_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/rcdh_step.sv
// ----------------------------------------------------------------------------
// rcdh_step
// Next-state logic for one request: start checks, pulse priority, tick
// safety checks and seek timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdh_step import rcdh_pkg::*; (
    input  wire t_request i_req,
    input  wire t_config  i_config,
    input  wire t_state   i_state,
    output t_state        o_state,
    output logic          o_rejected
);

    always_comb begin
        t_state                 s;
        logic                   start_ok;
        logic [COUNT_WIDTH-1:0] cnt_inc;
        logic [TIMER_WIDTH-1:0] el_inc;

        s        = i_state;
        start_ok = (i_req.rotations != '0) && (i_req.rotations <= i_config.dispense_max);
        cnt_inc  = (i_state.count != COUNT_MAX) ? i_state.count + 1'b1 : i_state.count;
        el_inc   = (i_state.elapsed != TIMER_MAX) ? i_state.elapsed + 1'b1
                                                  : i_state.elapsed;
        o_rejected = 1'b0;

        case (i_req.command)
            CMD_TICK: begin
                // End runs that already reached their limit
                if (i_state.dispense && (i_state.count >= i_state.target)) begin
                    s.motor    = 1'b0;
                    s.dispense = 1'b0;
                end
                if (i_state.home && (i_state.count >= i_config.home_max)) begin
                    s.motor = 1'b0;
                    s.home  = 1'b0;
                    s.done  = 1'b1;
                end
                // Advance seek timer, fail on timeout or lost feedback
                if (i_state.seek) begin
                    s.elapsed = el_inc;
                    if (el_inc > i_config.seek_timeout) begin
                        s.motor = 1'b0;
                        s.seek  = 1'b0;
                        s.done  = 1'b0;
                        s.error = 1'b1;
                    end else if (!i_req.motor_running) begin
                        s.seek = 1'b0;
                        s.done = 1'b0;
                    end
                end
                // Drop runs whose motor stopped turning
                if ((s.dispense || s.home) && !i_req.motor_running) begin
                    s.dispense = 1'b0;
                    s.home     = 1'b0;
                end
            end
            CMD_PULSE: begin
                s.count = cnt_inc;
                if (i_state.seek) begin
                    s.motor = 1'b0;
                    s.seek  = 1'b0;
                    s.done  = 1'b1;
                end else if (i_state.home && (cnt_inc >= i_config.home_max)) begin
                    s.motor = 1'b0;
                    s.home  = 1'b0;
                    s.done  = 1'b1;
                end else if ((cnt_inc >= i_state.target) && i_state.dispense) begin
                    s.motor    = 1'b0;
                    s.dispense = 1'b0;
                end
            end
            CMD_DISPENSE: begin
                if (!start_ok) begin
                    o_rejected = 1'b1;
                end else begin
                    s.count    = '0;
                    s.target   = i_req.rotations;
                    s.dispense = 1'b1;
                    s.motor    = 1'b1;
                    s.speed    = i_req.speed;
                end
            end
            CMD_HOME: begin
                if (!start_ok) begin
                    o_rejected = 1'b1;
                end else begin
                    s.count    = '0;
                    s.target   = i_req.rotations;
                    s.dispense = 1'b0;
                    s.home     = 1'b1;
                    s.done     = 1'b0;
                    s.motor    = 1'b1;
                    s.speed    = i_req.speed;
                end
            end
            CMD_SEEK: begin
                s.dispense = 1'b0;
                s.home     = 1'b0;
                s.seek     = 1'b1;
                s.done     = 1'b0;
                s.error    = 1'b0;
                s.count    = '0;
                s.elapsed  = '0;
                s.motor    = 1'b1;
                s.speed    = i_req.speed;
            end
            CMD_CLEAR: begin
                s.error = 1'b0;
            end
            default: begin
            end
        endcase

        o_state = s;
    end

endmodule

`default_nettype wire

FILE: design/rotation_count_dispense_home_sequencer.sv
// ----------------------------------------------------------------------------
// rotation_count_dispense_home_sequencer
// Motor run sequencer counting one sensor pulse per revolution, with
// dispense, home and home-seek jobs and a millisecond tick for timeouts.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      contents
//  i_req     in   valid/ready    command, rotations, speed, motor_running
//  o_rsp     out  valid/ready    motor and job status after the request
//  i_cfg     in   valid/ready    register index, write data (always ready)
//
//  One request a cycle unless the result stalls. A request is held in the
//  input register, then updates the job state and loads the result register.
//  A stalled result holds; the input register still takes a request while
//  the result register is free or being drained.
//  Reset (i_rst_n low, synchronous) clears the job state and both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_count_dispense_home_sequencer import rcdh_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rcdh_req_if.sink   i_req,
    rcdh_rsp_if.source o_rsp,
    rcdh_cfg_if.sink   i_cfg
);

    t_config  w_config;
    t_request r_in;
    logic     r_in_v;
    t_state   r_state;
    t_state   n_state;
    logic     w_rejected;
    t_result  r_out;
    logic     r_out_v;
    logic     w_adv;
    logic     w_in_ready;

    rcdh_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_config (w_config)
    );

    rcdh_step u_step (
        .i_req      (r_in),
        .i_config   (w_config),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_rejected (w_rejected)
    );

    // Advance when a request waits and the result register can take it
    assign w_adv      = r_in_v && (!r_out_v || o_rsp.ready);
    assign w_in_ready = !r_in_v || w_adv;
    assign i_req.ready = w_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_ready) begin
            r_in_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_in.command       <= i_req.command;
            r_in.rotations     <= i_req.rotations;
            r_in.speed         <= i_req.speed;
            r_in.motor_running <= i_req.motor_running;
        end
    end

    // Job state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.motor_enable    <= n_state.motor;
            r_out.motor_speed     <= n_state.speed;
            r_out.rotation_count  <= n_state.count;
            r_out.dispense_active <= n_state.dispense;
            r_out.home_active     <= n_state.home;
            r_out.seek_active     <= n_state.seek;
            r_out.home_done       <= n_state.done;
            r_out.error_code      <= n_state.error;
            r_out.start_rejected  <= w_rejected;
        end
    end

    assign o_rsp.valid           = r_out_v;
    assign o_rsp.motor_enable    = r_out.motor_enable;
    assign o_rsp.motor_speed     = r_out.motor_speed;
    assign o_rsp.rotation_count  = r_out.rotation_count;
    assign o_rsp.dispense_active = r_out.dispense_active;
    assign o_rsp.home_active     = r_out.home_active;
    assign o_rsp.seek_active     = r_out.seek_active;
    assign o_rsp.home_done       = r_out.home_done;
    assign o_rsp.error_code      = r_out.error_code;
    assign o_rsp.start_rejected  = r_out.start_rejected;

`ifndef NO_ASSERTIONS
    // Job state moves only with a request
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_adv)) |-> $stable(r_state))
        else $error("job state changed without a request");

    // An empty result register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> w_in_ready)
        else $error("input stalled while result register empty");

    // A seek timeout error is raised only by a tick
    a_error_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_state.error)) |->
            ($past(w_adv) && ($past(r_in.command) == CMD_TICK)))
        else $error("error raised by a request other than a tick");
`endif

endmodule

`default_nettype wire
